/* rtl/utfd_pkg.sv */
// ----------------------------------------------------------------------------
// utfd_pkg
// Shared types and constants for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package utfd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] BomValue = 21'h00FEFF;

  // result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // classified byte, as passed from front to back
  typedef enum logic [2:0] {
    OP_CONT,
    OP_ASCII,
    OP_LEAD,
    OP_BAD,
    OP_END
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [1:0]  len;   // continuations a lead byte expects
    logic [6:0]  data;  // payload bits of the byte, already masked
  } op_t;

  typedef struct packed {
    logic           kind;
    logic [CpW-1:0] code_point;
    logic [1:0]     miss;
    logic           bad_start;
    logic           last;
  } res_t;

endpackage

/* rtl/utf8_byte_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// Byte-wise UTF-8 decoder with queue-style ports on both sides.
// ----------------------------------------------------------------------------
//  channel  | handshake                          | payload
//  ---------+------------------------------------+-----------------------------
//  bytes in | push, full (accept: push & !full)  | in_byte_i, end_of_input_i
//  results  | empty, pop (accept: pop & !empty)  | kind_o, code_point_o,
//           |                                    | missing_continuations_o,
//           |                                    | bad_start_seen_o, last_o
//
// One byte per cycle sustained while full is low. A byte is classified on
// entry and queued; the decode stage takes one queued byte a cycle when the
// result queue has two free slots, and writes both results of a byte in the
// same cycle. Each result passes the registered byte queue, then the result queue.
// Reset clears both queues and the decode state.
// ----------------------------------------------------------------------------
module utf8_byte_decoder import utfd_pkg::*; #(
  parameter int unsigned OpDepth  = 4,
  parameter int unsigned ResDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [20:0] code_point_o,
  output logic [1:0]  missing_continuations_o,
  output logic        bad_start_seen_o,
  output logic        last_o
);

  localparam int unsigned OpCntW  = $clog2(OpDepth+1);
  localparam int unsigned ResCntW = $clog2(ResDepth+1);

  op_t                op_in, op_out;
  logic               op_push, op_empty, op_pop;
  logic [OpCntW-1:0]  op_space;
  logic               res_wr0, res_wr1;
  res_t               res0, res1, res_head;
  logic [ResCntW-1:0] res_space;

  utfd_front u_front (
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .op_o           (op_in)
  );

  assign full    = (op_space == '0);
  assign op_push = push && !full;

  utfd_fifo #(
    .Width ($bits(op_t)),
    .Depth (OpDepth)
  ) u_op_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr0_i      (op_push),
    .wr0_data_i (op_in),
    .wr1_i      (1'b0),
    .wr1_data_i (op_in),
    .rd_i       (op_pop),
    .rd_data_o  (op_out),
    .empty_o    (op_empty),
    .space_o    (op_space)
  );

  utfd_back #(
    .CntW (ResCntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_space_i (res_space),
    .res_wr0_o   (res_wr0),
    .res0_o      (res0),
    .res_wr1_o   (res_wr1),
    .res1_o      (res1)
  );

  utfd_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr0_i      (res_wr0),
    .wr0_data_i (res0),
    .wr1_i      (res_wr1),
    .wr1_data_i (res1),
    .rd_i       (pop && !empty),
    .rd_data_o  (res_head),
    .empty_o    (empty),
    .space_o    (res_space)
  );

  assign kind_o                  = res_head.kind;
  assign code_point_o            = res_head.code_point;
  assign missing_continuations_o = res_head.miss;
  assign bad_start_seen_o        = res_head.bad_start;
  assign last_o                  = res_head.last;

endmodule

/* rtl/utfd_fifo.sv */
// ----------------------------------------------------------------------------
// utfd_fifo
// Small register queue; takes up to two entries and gives one per cycle.
// ----------------------------------------------------------------------------
module utfd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr0_i,
  input  logic [Width-1:0]           wr0_data_i,
  input  logic                       wr1_i,
  input  logic [Width-1:0]           wr1_data_i,
  input  logic                       rd_i,
  output logic [Width-1:0]           rd_data_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] space_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nxt;
  logic [CntW-1:0]  count_q, count_d;

  assign wptr_nxt = (AddrW'(wptr_q + AddrW'(1)) == AddrW'(Depth)) ? '0 : wptr_q + AddrW'(1);

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr0_i) begin
      wptr_d = wptr_nxt;
      if (wr1_i) begin
        wptr_d = (AddrW'(wptr_nxt + AddrW'(1)) == AddrW'(Depth)) ? '0 : wptr_nxt + AddrW'(1);
      end
    end
    if (rd_i) begin
      rptr_d = (AddrW'(rptr_q + AddrW'(1)) == AddrW'(Depth)) ? '0 : rptr_q + AddrW'(1);
    end
    count_d = count_q + CntW'(wr0_i) + CntW'(wr0_i & wr1_i) - CntW'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr0_i) begin
      mem_q[wptr_q] <= wr0_data_i;
    end
    if (wr0_i && wr1_i) begin
      mem_q[wptr_nxt] <= wr1_data_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];
  assign empty_o   = (count_q == '0);
  assign space_o   = CntW'(Depth) - count_q;

  a_wr1_needs_wr0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr1_i |-> wr0_i)
    else $error("second write without first");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr0_i |-> (space_o + CntW'(rd_i)) >= (CntW'(1) + CntW'(wr1_i)))
    else $error("queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("read from empty queue");

endmodule

/* rtl/utfd_front.sv */
// ----------------------------------------------------------------------------
// utfd_front
// Sorts each incoming byte into continuation, ASCII, lead, invalid or end.
// ----------------------------------------------------------------------------
module utfd_front import utfd_pkg::*; (
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output op_t        op_o
);

  always_comb begin
    op_o      = '0;
    op_o.kind = OP_END;
    priority if (end_of_input_i) begin
      op_o.kind = OP_END;
    end else if (in_byte_i[7:6] == 2'b10) begin
      op_o.kind = OP_CONT;
      op_o.data = {1'b0, in_byte_i[5:0]};
    end else if (!in_byte_i[7]) begin
      op_o.kind = OP_ASCII;
      op_o.data = in_byte_i[6:0];
    end else if (in_byte_i > 8'hF4) begin
      op_o.kind = OP_BAD;
    end else if (in_byte_i < 8'hE0) begin
      op_o.kind = OP_LEAD;
      op_o.len  = 2'd1;
      op_o.data = {2'b00, in_byte_i[4:0]};
    end else if (in_byte_i < 8'hF0) begin
      op_o.kind = OP_LEAD;
      op_o.len  = 2'd2;
      op_o.data = {3'b000, in_byte_i[3:0]};
    end else begin
      op_o.kind = OP_LEAD;
      op_o.len  = 2'd3;
      op_o.data = {4'b0000, in_byte_i[2:0]};
    end
  end

endmodule

/* rtl/utfd_back.sv */
// ----------------------------------------------------------------------------
// utfd_back
// Sequence state: assembles code points and writes zero, one or two results.
// ----------------------------------------------------------------------------
module utfd_back import utfd_pkg::*; #(
  parameter int unsigned CntW = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  input  op_t             op_i,
  output logic            op_pop_o,
  input  logic [CntW-1:0] res_space_i,
  output logic            res_wr0_o,
  output res_t            res0_o,
  output logic            res_wr1_o,
  output res_t            res1_o
);

  logic [1:0]     pend_q, pend_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic           bad_q, bad_d;
  logic           fin_q, fin_d;

  logic           fire;
  logic [CpW-1:0] flush_cp, merged;
  logic           c0v, c1v;
  res_t           c0, c1;

  // worst case is two results per byte
  assign fire     = op_valid_i && (res_space_i >= CntW'(2));
  assign op_pop_o = fire;

  // missing continuations shift in as zero bits
  always_comb begin
    unique case (pend_q)
      2'd1:    flush_cp = {acc_q[14:0], 6'b0};
      2'd2:    flush_cp = {acc_q[8:0], 12'b0};
      2'd3:    flush_cp = {acc_q[2:0], 18'b0};
      default: flush_cp = acc_q;
    endcase
  end

  assign merged = {acc_q[14:0], op_i.data[5:0]};

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    bad_d  = bad_q;
    fin_d  = fin_q;
    c0v    = 1'b0;
    c1v    = 1'b0;
    c0     = '0;
    c1     = '0;
    if (fire && !fin_q) begin
      if (op_i.kind == OP_CONT) begin
        if (pend_q != 2'd0) begin
          if (pend_q == 2'd1) begin
            pend_d = 2'd0;
            acc_d  = '0;
            if (merged != BomValue) begin
              c0v = 1'b1;
              c0  = '{kind: KindChar, code_point: merged, miss: 2'd0,
                      bad_start: bad_d, last: 1'b0};
              bad_d = 1'b0;
            end
          end else begin
            pend_d = pend_q - 2'd1;
            acc_d  = merged;
          end
        end else begin
          bad_d = 1'b1;
        end
      end else begin
        // broken sequence or end: flush what is pending first
        if (pend_q != 2'd0) begin
          pend_d = 2'd0;
          acc_d  = '0;
          if (flush_cp != BomValue) begin
            c0v = 1'b1;
            c0  = '{kind: KindChar, code_point: flush_cp, miss: pend_q,
                    bad_start: bad_d, last: 1'b0};
            bad_d = 1'b0;
          end
        end
        unique case (op_i.kind)
          OP_END: begin
            c1v   = 1'b1;
            c1    = '{kind: KindEnd, code_point: '0, miss: 2'd0,
                      bad_start: bad_d, last: 1'b0};
            bad_d = 1'b0;
            fin_d = 1'b1;
          end
          OP_ASCII: begin
            c1v   = 1'b1;
            c1    = '{kind: KindChar, code_point: CpW'(op_i.data), miss: 2'd0,
                      bad_start: bad_d, last: 1'b0};
            bad_d = 1'b0;
          end
          OP_LEAD: begin
            pend_d = op_i.len;
            acc_d  = CpW'(op_i.data);
          end
          default: begin
            bad_d = 1'b1;
          end
        endcase
      end
    end
  end

  // pack results so the first written is always slot 0
  always_comb begin
    res_wr0_o = c0v | c1v;
    res_wr1_o = c0v & c1v;
    res0_o    = c0v ? c0 : c1;
    res1_o    = c1;
    res0_o.last = !(c0v & c1v);
    res1_o.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      bad_q  <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      bad_q  <= bad_d;
      fin_q  <= fin_d;
    end
  end

  a_silent_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !res_wr0_o)
    else $error("result after end of input");

  a_pair_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr1_o |-> (res_wr0_o && res_space_i >= CntW'(2)))
    else $error("second result without room");

  a_last_marks_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr1_o |-> (res1_o.last && !res0_o.last))
    else $error("last flag misplaced in result pair");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_byte_decoder. A short directed table covers the
// byte classes, overlongs, surrogates, the byte order mark and broken
// sequences. Random, mostly well-formed sequences follow, then one end-of-input
// transaction and three with a random end flag. Results are checked field by
// field against the table or a decoder model, with random idling on both ports.
// ----------------------------------------------------------------------------
module testbench;
  import utfd_pkg::*;

  // one byte transaction; typed rows carry their expected character
  typedef struct packed {
    logic [7:0]     data;
    logic           eoi;
    logic           typed;
    logic           n_res;
    logic [CpW-1:0] cp;
    logic           bad;
  } stim_t;

  localparam int unsigned RandItems = 1200;
  localparam int unsigned DrainAt   = 500;
  localparam int unsigned HoldAt    = 400;
  localparam int unsigned HoldLen   = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        end_in;
  logic        empty;
  logic        pop;
  logic        kind;
  logic [20:0] code_point;
  logic [1:0]  miss;
  logic        bad_start;
  logic        last;

  stim_t       stim_q [$];
  res_t        chars_due [$];   // expected results, oldest first
  res_t        step_out [$];    // results of the byte being decoded
  int unsigned n_errors = 0;
  int unsigned n_popped = 0;
  bit          sent_all = 1'b0;

  // decoder model state
  logic [1:0]     pend     = '0;
  logic [CpW-1:0] acc      = '0;
  logic           bad_flag = 1'b0;
  logic           done     = 1'b0;

  always #2 clk_i = ~clk_i;

  utf8_byte_decoder u_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .push                    (push),
    .full                    (full),
    .in_byte_i               (in_byte),
    .end_of_input_i          (end_in),
    .empty                   (empty),
    .pop                     (pop),
    .kind_o                  (kind),
    .code_point_o            (code_point),
    .missing_continuations_o (miss),
    .bad_start_seen_o        (bad_start),
    .last_o                  (last)
  );

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------
  task automatic put_result(input logic k, input logic [CpW-1:0] cp, input logic [1:0] m);
    res_t r;
    r.kind       = k;
    r.code_point = cp;
    r.miss       = m;
    r.bad_start  = bad_flag;
    r.last       = 1'b0;
    bad_flag     = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic emit_char(input logic [CpW-1:0] cp, input logic [1:0] m);
    if (cp != BomValue) put_result(KindChar, cp, m);
  endtask

  // pad a pending character with zero bits
  task automatic flush_pending();
    logic [CpW-1:0] cp;
    logic [1:0]     m;
    m   = pend;
    cp  = acc;
    repeat (m) cp = cp << 6;
    pend = '0;
    acc  = '0;
    emit_char(cp, m);
  endtask

  task automatic take_head_byte(input logic [7:0] b);
    if (b[7:6] == 2'b10 || b > 8'hF4) begin
      bad_flag = 1'b1;
    end else if (b < 8'h80) begin
      emit_char({13'b0, b}, 2'd0);
    end else if (b < 8'hE0) begin
      pend = 2'd1;
      acc  = {16'b0, b[4:0]};
    end else if (b < 8'hF0) begin
      pend = 2'd2;
      acc  = {17'b0, b[3:0]};
    end else begin
      pend = 2'd3;
      acc  = {18'b0, b[2:0]};
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    step_out.delete();
    if (done) return;
    if (eoi) begin
      if (pend != 0) flush_pending();
      put_result(KindEnd, '0, 2'd0);
      done = 1'b1;
    end else if (pend != 0) begin
      if (b[7:6] == 2'b10) begin
        acc  = {acc[CpW-7:0], b[5:0]};
        pend = pend - 2'd1;
        if (pend == 0) begin
          emit_char(acc, 2'd0);
          acc = '0;
        end
      end else begin
        flush_pending();
        take_head_byte(b);
      end
    end else begin
      take_head_byte(b);
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endtask

  task automatic commit_item(input stim_t it);
    res_t r;
    decode_byte(it.data, it.eoi);
    if (it.typed) begin
      if (it.n_res) begin
        r.kind       = KindChar;
        r.code_point = it.cp;
        r.miss       = 2'd0;
        r.bad_start  = it.bad;
        r.last       = 1'b1;
        chars_due.push_back(r);
      end
    end else begin
      foreach (step_out[k]) chars_due.push_back(step_out[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic eoi);
    stim_q.push_back({b, eoi, 1'b0, 1'b0, 21'h0, 1'b0});
  endtask

  task automatic gen_random(input int unsigned target);
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  lead;
    while (stim_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
      end else if (r < 88) begin
        len = $urandom_range(1, 3);
        case (len)
          1:       lead = 8'($urandom_range(8'hC0, 8'hDF));
          2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
          default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        if (len == 2 && $urandom_range(0, 15) == 0) begin
          // byte order mark
          queue_byte(8'hEF, 1'b0);
          queue_byte(8'hBB, 1'b0);
          queue_byte(8'hBF, 1'b0);
        end else begin
          cut = (r < 78) ? len : $urandom_range(0, len - 1);
          queue_byte(lead, 1'b0);
          repeat (cut) queue_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        end
      end else begin
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // mostly short gaps, a few long, and whole stretches with none
  function automatic int unsigned idle_len(input int unsigned n);
    int unsigned r;
    if ((n / 128) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  task automatic cmp_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      note_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                              n_popped, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // processes
  // --------------------------------------------------------------------------
  initial begin : sender
    stim_t       dir_tab [24];
    stim_t       it;
    int unsigned gap;
    push    = 1'b0;
    in_byte = '0;
    end_in  = 1'b0;
    //            data   eoi   typed n_res cp          bad
    dir_tab = '{
      {8'h00, 1'b0, 1'b1, 1'b1, 21'h000000, 1'b0},
      {8'h7F, 1'b0, 1'b1, 1'b1, 21'h00007F, 1'b0},
      {8'h80, 1'b0, 1'b1, 1'b0, 21'h0,      1'b0},  // stray continuation
      {8'hFF, 1'b0, 1'b1, 1'b0, 21'h0,      1'b0},  // never a start byte
      {8'hEF, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},  // byte order mark, dropped
      {8'hBB, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'h41, 1'b0, 1'b1, 1'b1, 21'h000041, 1'b1},  // flag carried past the mark
      {8'hC0, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},  // overlong lead
      {8'h80, 1'b0, 1'b1, 1'b1, 21'h000000, 1'b0},
      {8'hDF, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hBF, 1'b0, 1'b1, 1'b1, 21'h0007FF, 1'b0},
      {8'hED, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},  // surrogate
      {8'hA0, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'h80, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hF4, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},  // top of the four-byte range
      {8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hF5, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hE1, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},  // broken by an ASCII byte
      {8'h41, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},
      {8'hF0, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0},  // broken by an invalid byte
      {8'hFE, 1'b0, 1'b0, 1'b0, 21'h0,      1'b0}
    };
    foreach (dir_tab[k]) stim_q.push_back(dir_tab[k]);
    gen_random(RandItems);
    // tail: a pending character to flush, an invalid byte, or a clean end
    case ($urandom_range(0, 2))
      0: begin
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
      end
      1: queue_byte(8'hFE, 1'b0);
      default: ;
    endcase
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (3) queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    wait (rst_ni === 1'b1);
    for (int unsigned i = 0; i < stim_q.size(); i++) begin
      it = stim_q[i];
      if (i == DrainAt) begin
        @(negedge clk_i);
        push <= 1'b0;
        while (chars_due.size() != 0) @(negedge clk_i);
      end
      gap = idle_len(i);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
      @(negedge clk_i);
      push    <= 1'b1;
      in_byte <= it.data;
      end_in  <= it.eoi;
      do @(posedge clk_i); while (full !== 1'b0);
      commit_item(it);
    end
    @(negedge clk_i);
    push     <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin : receiver
    res_t        want;
    int unsigned gap;
    bit          held;
    pop  = 1'b0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      // one long hold-off so the input side backs up
      if (!held && n_popped >= HoldAt) begin
        held = 1'b1;
        repeat (HoldLen) begin
          @(negedge clk_i);
          pop <= 1'b0;
        end
      end
      gap = idle_len(n_popped);
      repeat (gap) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      if (chars_due.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing expected", n_popped));
      end else begin
        want = chars_due.pop_front();
        cmp_field("kind", 32'(kind), 32'(want.kind));
        cmp_field("code_point", 32'(code_point), 32'(want.code_point));
        cmp_field("missing_continuations", 32'(miss), 32'(want.miss));
        cmp_field("bad_start_seen", 32'(bad_start), 32'(want.bad_start));
        cmp_field("last", 32'(last), 32'(want.last));
      end
      n_popped++;
    end
  end

  initial begin : control
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (sent_all);
    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
